/* hdl/stst_pkg.sv */
// Shared types, constants and helper functions for the source table sequence tracker.
// Used by every module of the tracker but stst_ram; depends on nothing else.
package stst_pkg;

	// Table geometry.
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Stream widths: input fields packed low to high, results padded to whole bytes.
	localparam int IN_W      = 192;
	localparam int OUT_BITS  = 167;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// Packet classification codes.
	typedef enum logic [1:0] {
		VERDICT_NEW = 2'd0,
		VERDICT_FWD = 2'd1,
		VERDICT_DUP = 2'd2,
		VERDICT_OOO = 2'd3
	} verdict_t;

	// One table entry as held in the slot memory.
	typedef struct packed {
		logic [63:0] key;
		logic [31:0] origin_seq;
		logic [31:0] recent_seq;
		logic [63:0] last_time;
		logic [31:0] received;
		logic [31:0] duplicates;
		logic [31:0] reordered;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	// Fields of the packet under work.
	typedef struct packed {
		logic [63:0] key;
		logic [31:0] seq;
		logic [63:0] now;
	} pkt_t;

	// Outcome of the sweep over the table.
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] hit_idx;
		slot_rec_t         hit_rec;
		logic              free;
		logic [SLOT_W-1:0] free_idx;
		logic [SLOT_W-1:0] oldest_idx;
	} scan_res_t;

	// Saturating increment of a 32-bit counter.
	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

	// Low four bits of a slot number, zero-extended when the table is small.
	function automatic logic [3:0] idx_low4(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W+3:0] wide;
		wide = {4'b0000, idx};
		return wide[3:0];
	endfunction

endpackage

/* hdl/stst_ram.sv */
// Generic single-port-write, single-port-read memory with registered read data.
// Standalone; used for the slot table of the tracker.
module stst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* hdl/stst_scan.sv */
// Slot evaluation unit: compares one table entry per cycle, while eval_en is high, against the packet.
// Tracks the first hit, the first free slot and the oldest last-seen time; uses stst_pkg.
module stst_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          eval_en,
	input  logic [stst_pkg::SLOT_W-1:0]   eval_idx,
	input  logic [stst_pkg::NUM_SLOTS-1:0] valid_vec,
	input  stst_pkg::slot_rec_t           rec,
	input  logic [63:0]                   key,
	output stst_pkg::scan_res_t           res
);
	import stst_pkg::*;

	logic              hit_q;
	logic              free_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic [SLOT_W-1:0] oldest_idx_q;
	logic [63:0]       oldest_time_q;
	slot_rec_t         hit_rec_q;
	logic              slot_v;
	logic              key_eq;
	logic              older;

	// Shared comparators for the entry on the read port.
	assign slot_v = valid_vec[eval_idx];
	assign key_eq = (rec.key == key);
	assign older  = ($signed(rec.last_time) < $signed(oldest_time_q));

	// Control flags of the sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (eval_en) begin
			if (slot_v && key_eq) begin
				hit_q <= 1'b1;
			end
			if (!slot_v) begin
				free_q <= 1'b1;
			end
		end
	end

	// Captured indexes, the hit entry and the running minimum of last-seen times.
	always_ff @(posedge clk) begin
		if (eval_en) begin
			if (slot_v && key_eq && !hit_q) begin
				hit_idx_q <= eval_idx;
				hit_rec_q <= rec;
			end
			if (!slot_v && !free_q) begin
				free_idx_q <= eval_idx;
			end
			if (eval_idx == '0 || older) begin
				oldest_idx_q  <= eval_idx;
				oldest_time_q <= rec.last_time;
			end
		end
	end

	assign res = '{
		hit:        hit_q,
		hit_idx:    hit_idx_q,
		hit_rec:    hit_rec_q,
		free:       free_q,
		free_idx:   free_idx_q,
		oldest_idx: oldest_idx_q
	};
endmodule

/* hdl/stst_update.sv */
// Entry update datapath: classifies a hit or builds a fresh entry for a miss.
// Produces the slot to write, the new entry and the result fields; uses stst_pkg.
module stst_update (
	input  stst_pkg::pkt_t             pkt,
	input  stst_pkg::scan_res_t        res,
	output logic [stst_pkg::SLOT_W-1:0] sel,
	output stst_pkg::verdict_t         verdict,
	output logic                       evicted,
	output stst_pkg::slot_rec_t        new_rec
);
	import stst_pkg::*;

	logic [31:0] diff;
	slot_rec_t   cur;

	assign cur  = res.hit_rec;
	assign diff = pkt.seq - cur.recent_seq;

	// Hits are classified by the wrapping signed sequence step; misses reinitialize a slot.
	always_comb begin
		new_rec = cur;
		sel     = res.hit_idx;
		verdict = VERDICT_FWD;
		evicted = 1'b0;
		if (res.hit) begin
			if (diff == 32'd0) begin
				verdict            = VERDICT_DUP;
				new_rec.duplicates = sat_inc(cur.duplicates);
			end else if (diff[31]) begin
				verdict           = VERDICT_OOO;
				new_rec.reordered = sat_inc(cur.reordered);
			end else begin
				verdict            = VERDICT_FWD;
				new_rec.recent_seq = pkt.seq;
			end
			new_rec.received = sat_inc(cur.received);
		end else begin
			sel                = res.free ? res.free_idx : res.oldest_idx;
			evicted            = !res.free;
			verdict            = VERDICT_NEW;
			new_rec.key        = pkt.key;
			new_rec.origin_seq = pkt.seq;
			new_rec.recent_seq = pkt.seq;
			new_rec.received   = 32'd1;
			new_rec.duplicates = 32'd0;
			new_rec.reordered  = 32'd0;
		end
		new_rec.last_time = pkt.now;
	end
endmodule

/* hdl/source_table_seq_tracker.sv */
// Per-sender sequence tracker over a fixed table of NUM_SLOTS slots.
// A packet passes ST_SCAN, ST_DRAIN and ST_UPDATE, then its result is registered; a new
// packet is taken only in ST_IDLE. The sweep reads one entry per cycle over the slot memory
// read port; a waiting result lets the next packet be swept but holds back its write-back.
// Reset clears all slot valid bits at once; slot memory contents need no clearing.
module source_table_seq_tracker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// sender_id[63:0], seq_num[95:64], rx_time[159:96], interval[191:160]
	input  logic [stst_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// slot_index[3:0], verdict[5:4], evicted[6], received_total[38:7],
	// duplicate_total[70:39], reorder_total[102:71], first_sequence[134:103],
	// highest_sequence[166:135], zero pad[167]
	output logic [stst_pkg::OUT_W-1:0] m_tdata
);
	import stst_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  cnt_q;
	logic               eval_vld_s1;
	logic [SLOT_W-1:0]  eval_idx_s1;
	logic [NUM_SLOTS-1:0] valid_q;
	pkt_t               pkt_q;
	logic               out_vld_q;
	logic [OUT_W-1:0]   out_q;

	logic               accept;
	logic               commit;
	slot_rec_t          rd_rec;
	scan_res_t          res;
	logic [SLOT_W-1:0]  sel;
	verdict_t           verdict;
	logic               evicted;
	slot_rec_t          new_rec;
	logic [OUT_BITS-1:0] out_fields;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_UPDATE) && (!out_vld_q || m_tready);

	// Slot table memory.
	stst_ram #(
		.WIDTH (REC_W),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (sel),
		.wdata (new_rec),
		.raddr (cnt_q),
		.rdata (rd_rec)
	);

	// Per-entry evaluation during the sweep.
	stst_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.eval_en   (eval_vld_s1),
		.eval_idx  (eval_idx_s1),
		.valid_vec (valid_q),
		.rec       (rd_rec),
		.key       (pkt_q.key),
		.res       (res)
	);

	// Entry update and result formation.
	stst_update u_update (
		.pkt     (pkt_q),
		.res     (res),
		.sel     (sel),
		.verdict (verdict),
		.evicted (evicted),
		.new_rec (new_rec)
	);

	// Sequencer: sweep the table, let the last read settle, then write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			eval_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					eval_vld_s1 <= 1'b0;
					if (accept) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					eval_vld_s1 <= 1'b1;
					if (cnt_q == SLOT_W'(NUM_SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					eval_vld_s1 <= 1'b0;
					state_q     <= ST_UPDATE;
				end
				ST_UPDATE: begin
					eval_vld_s1 <= 1'b0;
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					eval_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Index of the entry whose read data is on the memory read port, registered alongside it.
	always_ff @(posedge clk) begin
		eval_idx_s1 <= cnt_q;
	end

	// Packet fields held for the duration of the work.
	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_q.key <= s_tdata[63:0];
			pkt_q.seq <= s_tdata[95:64];
			pkt_q.now <= s_tdata[159:96];
		end
	end

	// Slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (commit) begin
			valid_q[sel] <= 1'b1;
		end
	end

	assign out_fields = {
		new_rec.recent_seq,
		new_rec.origin_seq,
		new_rec.reordered,
		new_rec.duplicates,
		new_rec.received,
		evicted,
		verdict,
		idx_low4(sel)
	};

	// Output register: holds one result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= OUT_W'(out_fields);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
endmodule

/* hdl/stst_checker.sv */
// Port-level checker for the source table sequence tracker, bound to the top level.
// Uses stst_pkg for the verdict codes and widths.
module stst_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [stst_pkg::OUT_W-1:0] m_tdata
);
	import stst_pkg::*;

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Each packet is swept before the next is taken: no transaction directly after another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in consecutive cycles");

	// Only a new entry can report an eviction.
	a_evict_new_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:4] != VERDICT_NEW) |-> !m_tdata[6])
		else $error("eviction reported on a hit");

	// A new entry starts with a received count of one and no duplicates or reorders.
	a_new_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:4] == VERDICT_NEW) |->
		(m_tdata[38:7] == 32'd1) && (m_tdata[70:39] == 32'd0) && (m_tdata[102:71] == 32'd0))
		else $error("new entry counters not initialized");

	// A new entry reports the same first and highest sequence number.
	a_new_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:4] == VERDICT_NEW) |-> (m_tdata[134:103] == m_tdata[166:135]))
		else $error("new entry sequence mismatch");
endmodule

bind source_table_seq_tracker stst_checker u_stst_checker (.*);

/* sim/tb_source_table_seq_tracker.sv */
// Self-checking testbench for the source table sequence tracker.
// Drives packets over the input stream, predicts each result from its own copy of the table,
// and checks every output transaction; depends only on stst_pkg and the tracker RTL.
module tb_source_table_seq_tracker;
	import stst_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 11;
	localparam int LATENCY      = NUM_SLOTS + 2;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int POOL_SIZE    = 24;
	localparam int PHASE_ITEMS  = 130;

	localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;

	// One received packet as offered on the input stream.
	typedef struct {
		logic [63:0]        sender_id;
		logic [31:0]        seq_num;
		logic signed [63:0] rx_time;
		logic [31:0]        interval;
	} packet_t;

	// One tracker result as it should leave the output stream.
	typedef struct {
		logic [3:0]  slot;
		verdict_t    verdict;
		logic        evicted;
		logic [31:0] received;
		logic [31:0] duplicates;
		logic [31:0] reordered;
		logic [31:0] origin_seq;
		logic [31:0] high_seq;
	} track_result_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic [IN_W-1:0]    s_tdata  = '0;
	logic               m_tready = 1'b0;
	logic               s_tready;
	logic               m_tvalid;
	logic [OUT_W-1:0]   m_tdata;

	// Shadow copy of the sender table.
	bit                 held_valid      [NUM_SLOTS];
	logic [63:0]        held_key        [NUM_SLOTS];
	logic [31:0]        held_origin_seq [NUM_SLOTS];
	logic [31:0]        held_recent_seq [NUM_SLOTS];
	logic signed [63:0] held_last_time  [NUM_SLOTS];
	logic [31:0]        held_received   [NUM_SLOTS];
	logic [31:0]        held_dups       [NUM_SLOTS];
	logic [31:0]        held_reorders   [NUM_SLOTS];

	track_result_t      pending_results[$];
	track_result_t      result_want;

	// Random traffic state: a pool of active senders and a running receive clock.
	logic [63:0]        pool_id  [POOL_SIZE];
	logic [31:0]        pool_seq [POOL_SIZE];
	logic signed [63:0] now_ns = 64'sd0;

	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	bit hold_request = 1'b0;
	int hold_left    = 0;
	int fail_count   = 0;
	int cycle_count  = 0;
	int packets_sent = 0;
	int results_seen = 0;
	int evict_seen   = 0;
	int verdict_seen [4];

	source_table_seq_tracker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Free-running clock.
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Saturating counter step.
	function automatic logic [31:0] bump_count(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Look the sender up, update the shadow table and return the expected result.
	function automatic track_result_t track_packet(input packet_t p);
		int            hit;
		int            sel;
		logic [31:0]   diff;
		track_result_t r;
		hit = -1;
		sel = -1;
		r.evicted = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (hit < 0 && held_valid[i] && held_key[i] == p.sender_id) begin
				hit = i;
			end
		end
		if (hit < 0) begin
			// Miss: lowest free slot, otherwise the least recently seen one.
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (sel < 0 && !held_valid[i]) begin
					sel = i;
				end
			end
			if (sel < 0) begin
				sel = 0;
				for (int i = 1; i < NUM_SLOTS; i++) begin
					if (held_last_time[i] < held_last_time[sel]) begin
						sel = i;
					end
				end
				r.evicted = 1'b1;
			end
			held_valid[sel]      = 1'b1;
			held_key[sel]        = p.sender_id;
			held_origin_seq[sel] = p.seq_num;
			held_recent_seq[sel] = p.seq_num;
			held_received[sel]   = 32'd0;
			held_dups[sel]       = 32'd0;
			held_reorders[sel]   = 32'd0;
			r.verdict = VERDICT_NEW;
		end else begin
			// Hit: classify by the wrapping signed sequence difference.
			sel  = hit;
			diff = p.seq_num - held_recent_seq[sel];
			if (diff == 32'd0) begin
				held_dups[sel] = bump_count(held_dups[sel]);
				r.verdict = VERDICT_DUP;
			end else if (diff[31]) begin
				held_reorders[sel] = bump_count(held_reorders[sel]);
				r.verdict = VERDICT_OOO;
			end else begin
				held_recent_seq[sel] = p.seq_num;
				r.verdict = VERDICT_FWD;
			end
		end
		held_last_time[sel] = p.rx_time;
		held_received[sel]  = bump_count(held_received[sel]);
		r.slot       = sel[3:0];
		r.received   = held_received[sel];
		r.duplicates = held_dups[sel];
		r.reordered  = held_reorders[sel];
		r.origin_seq = held_origin_seq[sel];
		r.high_seq   = held_recent_seq[sel];
		return r;
	endfunction

	// Offer one packet, with random idle cycles first, and record its expected result.
	// Starts and ends just after a falling edge; tvalid stays high for a following packet.
	task automatic send_packet(input packet_t p);
		track_result_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.interval, p.rx_time, p.seq_num, p.sender_id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = track_packet(p);
		pending_results.push_back(r);
		packets_sent++;
		verdict_seen[r.verdict]++;
		if (r.evicted) evict_seen++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected result has arrived.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Build one packet of random traffic: mostly well-behaved senders, some noise.
	function automatic packet_t make_random_packet();
		packet_t p;
		int      k;
		int      pick;
		int      when;
		k    = $urandom_range(POOL_SIZE - 1);
		pick = $urandom_range(99);
		if (pick < 12) begin
			pool_id[k]  = {$urandom, $urandom};
			pool_seq[k] = $urandom;
		end
		p.sender_id = pool_id[k];
		pick = $urandom_range(99);
		if (pick < 55) begin
			p.seq_num   = pool_seq[k] + $urandom_range(3, 1);
			pool_seq[k] = p.seq_num;
		end else if (pick < 65) begin
			p.seq_num = pool_seq[k];
		end else if (pick < 77) begin
			p.seq_num = pool_seq[k] - $urandom_range(50, 1);
		end else if (pick < 82) begin
			p.seq_num = pool_seq[k] + 32'h8000_0000;
		end else if (pick < 87) begin
			p.seq_num   = pool_seq[k] + ($urandom & 32'h7FFF_FFFF);
			pool_seq[k] = p.seq_num;
		end else begin
			p.seq_num = $urandom;
		end
		// Occasional stray packet from an unknown sender.
		if ($urandom_range(99) < 8) begin
			p.sender_id = {$urandom, $urandom};
			p.seq_num   = $urandom;
		end
		when = $urandom_range(99);
		if (when < 85) begin
			now_ns    = now_ns + $urandom_range(2000, 1);
			p.rx_time = now_ns;
		end else if (when < 92) begin
			now_ns    = now_ns - $urandom_range(2000, 1);
			p.rx_time = now_ns;
		end else begin
			p.rx_time = {$urandom, $urandom};
		end
		p.interval = $urandom;
		return p;
	endfunction

	// Compare one result field against its prediction.
	function automatic void check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Check every output transaction against the oldest expectation.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no packet waiting for it: slot_index %0d", m_tdata[3:0]);
				fail_count++;
			end else begin
				result_want = pending_results.pop_front();
				check_field("slot_index", result_want.slot, m_tdata[3:0]);
				check_field("verdict", result_want.verdict, m_tdata[5:4]);
				check_field("evicted", result_want.evicted, m_tdata[6]);
				check_field("received_total", result_want.received, m_tdata[38:7]);
				check_field("duplicate_total", result_want.duplicates, m_tdata[70:39]);
				check_field("reorder_total", result_want.reordered, m_tdata[102:71]);
				check_field("first_sequence", result_want.origin_seq, m_tdata[134:103]);
				check_field("highest_sequence", result_want.high_seq, m_tdata[166:135]);
				results_seen++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Watchdog expired after %0d cycles with %0d results outstanding.",
				cycle_count, pending_results.size());
			$display("** source_table_seq_tracker: FAILED **");
			$finish;
		end
	end

	// New entry, forward, duplicate and out-of-order on one sender, including the
	// half-way difference and the wrap of the sequence number.
	task automatic test_sequence_classes();
		packet_t p;
		logic [31:0] seqs [8];
		seqs = '{32'd0, 32'd1, 32'd1, 32'd0, 32'h8000_0001, 32'h8000_0000,
			32'hFFFF_FFFF, 32'd0};
		for (int i = 0; i < 8; i++) begin
			p.sender_id = 64'd0;
			p.seq_num   = seqs[i];
			p.rx_time   = (i == 7) ? TIME_MAX : 64'(i);
			p.interval  = (i % 2 == 0) ? 32'd0 : 32'hFFFF_FFFF;
			send_packet(p);
		end
	endtask

	// Fill the table with every last-seen time at the maximum, then evict twice:
	// the tie goes to slot 0, and then the minimum time makes slot 0 oldest again.
	task automatic test_full_table_eviction();
		packet_t p;
		for (int k = 1; k < NUM_SLOTS; k++) begin
			p.sender_id = 64'hFFFF_FFFF_FFFF_FFFF - 64'(k - 1);
			p.seq_num   = $urandom;
			p.rx_time   = TIME_MAX;
			p.interval  = $urandom;
			send_packet(p);
		end
		p.sender_id = 64'h5555_5555_5555_5555;
		p.seq_num   = 32'hFFFF_FFFF;
		p.rx_time   = TIME_MIN;
		p.interval  = 32'hFFFF_FFFF;
		send_packet(p);
		p.sender_id = 64'hAAAA_AAAA_AAAA_AAAA;
		p.seq_num   = 32'd0;
		p.rx_time   = 64'sd0;
		p.interval  = 32'd0;
		send_packet(p);
	endtask

	// Random traffic from a fresh pool of senders, more senders than slots.
	task automatic test_random_traffic(input int count);
		for (int k = 0; k < POOL_SIZE; k++) begin
			pool_id[k]  = {$urandom, $urandom};
			pool_seq[k] = $urandom;
		end
		for (int n = 0; n < count; n++) begin
			send_packet(make_random_packet());
		end
	endtask

	// Hold the output off for a long stretch while packets keep coming, so the
	// tracker fills up and stalls its input.
	task automatic test_backpressure_fill();
		@(posedge clk);
		hold_request = 1'b1;
		@(negedge clk);
		for (int n = 0; n < 12; n++) begin
			send_packet(make_random_packet());
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Sender idles seldom, receiver often.
		tx_idle_pct = 21;
		rx_idle_pct = 74;
		test_sequence_classes();
		test_full_table_eviction();
		wait_for_results();
		test_random_traffic(PHASE_ITEMS);
		wait_for_results();

		// Sender idles often, receiver seldom.
		tx_idle_pct = 74;
		rx_idle_pct = 21;
		test_random_traffic(PHASE_ITEMS);
		wait_for_results();

		// No idling on either side.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(PHASE_ITEMS);
		test_backpressure_fill();
		wait_for_results();

		repeat (4 * LATENCY) @(posedge clk);
		$display("Checked %0d results for %0d packets: %0d new, %0d forward, %0d duplicate,",
			results_seen, packets_sent, verdict_seen[VERDICT_NEW], verdict_seen[VERDICT_FWD],
			verdict_seen[VERDICT_DUP]);
		$display("%0d out of order, %0d evictions, under three idling mixes and a long stall.",
			verdict_seen[VERDICT_OOO], evict_seen);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("** source_table_seq_tracker: PASSED **");
		end else begin
			$display("** source_table_seq_tracker: FAILED **");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/stst_pkg.sv
hdl/stst_ram.sv
hdl/stst_scan.sv
hdl/stst_update.sv
hdl/source_table_seq_tracker.sv
hdl/stst_checker.sv
sim/tb_source_table_seq_tracker.sv
